// File: hw/rtl/lis_pkg.sv
// Shared types and helpers for the longest increasing subsequence scorer.
// Depends on nothing; imported by lis_cell and the top level.
`default_nettype none

package lis_pkg;

   localparam int unsigned VAL_W = 32;
   localparam int unsigned LEN_W = 9;
   localparam int unsigned LEN_FIELD_MAX = 511;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] end_length;
      logic [LEN_W-1:0] best_length;
      logic             overflow;
      logic             is_last;
   } rsp_type;

   // Transaction in flight along the cell chain. value_b is sign-biased so
   // that an unsigned compare gives signed order.
   typedef struct packed {
      logic             vld;
      logic [VAL_W-1:0] value_b;
      logic             last;
      logic             first;
      logic             stored;
      logic [LEN_W-1:0] best;
   } lis_token_type;

   function automatic logic [VAL_W-1:0] sign_bias(input logic [VAL_W-1:0] v);
      sign_bias = {~v[VAL_W-1], v[VAL_W-2:0]};
   endfunction

   // best predecessor length plus one, saturated at cap
   function automatic logic [LEN_W-1:0] len_step(input logic [LEN_W-1:0] best,
                                                input logic [LEN_W-1:0] cap);
      logic [LEN_W:0] inc;
      inc = {1'b0, best} + {{LEN_W{1'b0}}, 1'b1};
      if (inc > {1'b0, cap}) begin
         len_step = cap;
      end else begin
         len_step = inc[LEN_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/lis_cell.sv
// One cell of the scoring chain: holds one stored element and its length.
// Depends on lis_pkg.
`default_nettype none

module lis_cell #(
   parameter int unsigned LEN_CAP = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire lis_pkg::lis_token_type tok_i,
   output lis_pkg::lis_token_type      tok_o
);
   import lis_pkg::*;

   localparam logic [LEN_W-1:0] LenCapV = LEN_W'(LEN_CAP);

   logic             occ_ff, occ_in;
   logic [VAL_W-1:0] val_ff, val_in;
   logic [LEN_W-1:0] len_ff, len_in;
   lis_token_type    tok_ff, tok_in;
   logic             match, take;

   // first transaction of a sequence claims cell 0 and sweeps the rest empty
   assign match = occ_ff && !tok_i.first && (val_ff < tok_i.value_b) && (len_ff > tok_i.best);
   assign take  = tok_i.vld && !tok_i.stored && (tok_i.first || !occ_ff);

   always_comb begin
      occ_in = occ_ff;
      val_in = val_ff;
      len_in = len_ff;
      tok_in = tok_i;
      if (tok_i.vld) begin
         if (take) begin
            occ_in = 1'b1;
            val_in = tok_i.value_b;
            len_in = len_step(tok_i.best, LenCapV);
         end else if (tok_i.first) begin
            occ_in = 1'b0;
         end
         if (match) begin
            tok_in.best = len_ff;
         end
         tok_in.stored = tok_i.stored | take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff     <= 1'b0;
         tok_ff.vld <= 1'b0;
      end else if (adv) begin
         occ_ff <= occ_in;
         tok_ff <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         val_ff <= val_in;
         len_ff <= len_in;
      end
   end

   assign tok_o = tok_ff;

endmodule

`default_nettype wire

// File: hw/rtl/longest_increasing_subsequence.sv
// Longest strictly increasing subsequence scorer: top level.
// Depends on lis_pkg and lis_cell.
//
// Usage:
//  - req_data carries one signed 32-bit value and a last flag per transaction;
//    rsp_data returns one result per request, in order: the LIS length ending
//    at that value, the best length so far, overflow and an echo of last.
//  - Requests flow through a chain of MAX_ELEMS cells, one cell per cycle.
//    Each cell holds one earlier value of the sequence with its length; the
//    request picks up the best smaller entry and claims the first free cell.
//  - From acceptance to rsp_valid a request passes the register of every cell
//    and then the output register, which the last cell feeds directly.
//  - Throughput is one transaction per cycle while the output is not stalled,
//    set by the one-cell-per-cycle advance of the chain.
//  - A request that finds no free cell is scored but not stored, and comes
//    out with overflow set. After a last transaction the next request starts
//    a new sequence and empties the cells it passes.
//  - Reset empties every cell and the best length; no result is pending.
//  - While rsp_valid is high and rsp_ready low, the whole chain holds and
//    req_ready is low; one output register parts the chain from the receiver.
`default_nettype none

module longest_increasing_subsequence #(
   parameter int unsigned MAX_ELEMS = 256
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire lis_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output lis_pkg::rsp_type      rsp_data
);
   import lis_pkg::*;

   localparam int unsigned LenCap = (MAX_ELEMS < LEN_FIELD_MAX) ? MAX_ELEMS : LEN_FIELD_MAX;
   localparam logic [LEN_W-1:0] LenCapV = LEN_W'(LenCap);

   lis_token_type tok [MAX_ELEMS+1];
   logic          adv;
   logic          seq_start_ff, seq_start_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [LEN_W-1:0] best_ff, best_in, end_len, best_now;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      tok[0].vld     = req_valid;
      tok[0].value_b = sign_bias(req_data.value);
      tok[0].last    = req_data.last;
      tok[0].first   = seq_start_ff;
      tok[0].stored  = 1'b0;
      tok[0].best    = '0;
   end

   genvar g;
   generate
      for (g = 0; g < MAX_ELEMS; g++) begin : g_cell
         lis_cell #(
            .LEN_CAP(LenCap)
         ) u_cell (
            .clock(clock),
            .reset(reset),
            .adv  (adv),
            .tok_i(tok[g]),
            .tok_o(tok[g+1])
         );
      end
   endgenerate

   always_comb begin
      end_len      = len_step(tok[MAX_ELEMS].best, LenCapV);
      best_now     = (end_len > best_ff) ? end_len : best_ff;
      seq_start_in = seq_start_ff;
      best_in      = best_ff;
      rsp_valid_in = tok[MAX_ELEMS].vld;
      rsp_in       = rsp_ff;
      if (req_valid) begin
         seq_start_in = req_data.last;
      end
      if (tok[MAX_ELEMS].vld) begin
         best_in            = tok[MAX_ELEMS].last ? '0 : best_now;
         rsp_in.end_length  = end_len;
         rsp_in.best_length = best_now;
         rsp_in.overflow    = !tok[MAX_ELEMS].stored;
         rsp_in.is_last     = tok[MAX_ELEMS].last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_start_ff <= 1'b1;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         seq_start_ff <= seq_start_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hw/rtl/lis_checker.sv
// Port-level checks for the LIS scorer, bound to the top level.
// Depends on lis_pkg and longest_increasing_subsequence.
`default_nettype none

module lis_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire lis_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire lis_pkg::rsp_type rsp_data
);
   import lis_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req transaction dropped or changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction dropped or changed while stalled");

   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while the output is stalled");

   a_best_covers_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.best_length >= rsp_data.end_length
                    && rsp_data.end_length != '0)
      else $error("best length below end length");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result pending right after reset");

endmodule

bind longest_increasing_subsequence lis_checker u_lis_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

`default_nettype wire

// File: test/longest_increasing_subsequence_tb.sv
// Self-checking testbench for the longest increasing subsequence scorer.
// Depends on lis_pkg and longest_increasing_subsequence; scores every transaction
// in a local model and checks each response in order, with random idling both ways.
`timescale 1ns / 1ps

module longest_increasing_subsequence_tb;
   import lis_pkg::*;

   localparam int unsigned MAX_ELEMS    = 256;
   localparam int unsigned LEN_CAP      = (MAX_ELEMS < LEN_FIELD_MAX) ? MAX_ELEMS : LEN_FIELD_MAX;
   localparam int          RESET_CYCLES = 8;
   localparam int          TARGET_ITEMS = 1750;
   localparam int          IDLE_PCT     = 27;
   localparam int          QUIET_FIRST  = 700;   // no random idling on either side in this window
   localparam int          QUIET_LAST   = 1000;
   localparam int          DRAIN_CYCLES = MAX_ELEMS + 40;

   localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
   localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

   typedef struct {
      req_type data;
      bit      hold;   // wait for every outstanding response before sending
   } stim_item_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_item_type pending_items[$];
   rsp_type       expected_results[$];
   int            sent_count  = 0;
   int            recv_count  = 0;
   int            error_count = 0;

   // scoring state of the current sequence
   logic signed [VAL_W-1:0] seq_values[MAX_ELEMS];
   logic [LEN_W-1:0]        seq_lengths[MAX_ELEMS];
   int                      seq_count = 0;
   int                      seq_best  = 0;

   always #2 clock = ~clock;

   longest_increasing_subsequence #(
      .MAX_ELEMS(MAX_ELEMS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   function automatic rsp_type score_element(input req_type item);
      rsp_type                 res;
      logic signed [VAL_W-1:0] v;
      int                      best_prev;
      int                      end_len;
      v         = item.value;
      best_prev = 0;
      for (int i = 0; i < seq_count; i++) begin
         if (seq_values[i] < v && int'(seq_lengths[i]) > best_prev) begin
            best_prev = int'(seq_lengths[i]);
         end
      end
      end_len = best_prev + 1;
      if (end_len > LEN_CAP) begin
         end_len = LEN_CAP;
      end
      res.overflow = (seq_count >= MAX_ELEMS);
      if (!res.overflow) begin
         seq_values[seq_count]  = v;
         seq_lengths[seq_count] = end_len[LEN_W-1:0];
         seq_count++;
      end
      if (end_len > seq_best) begin
         seq_best = end_len;
      end
      res.end_length  = end_len[LEN_W-1:0];
      res.best_length = seq_best[LEN_W-1:0];
      res.is_last     = item.last;
      if (item.last) begin
         seq_count = 0;
         seq_best  = 0;
      end
      return res;
   endfunction

   task automatic add_item(input logic signed [VAL_W-1:0] v, input bit last, input bit hold);
      stim_item_type s;
      s.data.value = v;
      s.data.last  = last;
      s.hold       = hold;
      pending_items.push_back(s);
   endtask

   // mix of tight ranges (ties, short climbs and descents), full-range noise and extremes
   function automatic logic signed [VAL_W-1:0] pick_value(input logic signed [VAL_W-1:0] prev);
      int pick;
      pick = $urandom_range(99);
      if (pick < 35) begin
         return int'($urandom_range(32)) - 16;
      end else if (pick < 60) begin
         return prev + int'($urandom_range(4));
      end else if (pick < 85) begin
         return $urandom;
      end else if (pick < 92) begin
         return $urandom_range(1) ? VAL_MAX : VAL_MIN;
      end else begin
         return prev - int'($urandom_range(4));
      end
   endfunction

   task automatic build_stimulus;
      logic signed [VAL_W-1:0] v;
      int                      seq_len;
      int                      step;
      bit                      hold;
      // extremes of the value range, ties at both ends
      add_item(VAL_MIN, 1'b0, 1'b0);
      add_item(VAL_MAX, 1'b0, 1'b0);
      add_item(0, 1'b0, 1'b0);
      add_item(-1, 1'b0, 1'b0);
      add_item(1, 1'b0, 1'b0);
      add_item(VAL_MIN, 1'b0, 1'b0);
      add_item(VAL_MAX, 1'b1, 1'b0);
      // one-element sequence
      add_item(42, 1'b1, 1'b0);
      // strictly decreasing, then all equal
      for (int i = 5; i >= 1; i--) add_item(i, i == 1, 1'b0);
      for (int i = 0; i < 3; i++) add_item(7, i == 2, 1'b0);
      // strictly increasing across the sign boundary
      for (int i = -2; i <= 3; i++) add_item(i, i == 3, 1'b0);

      // fill past capacity with a strict climb: hits the length cap, last on an overflow
      v    = VAL_MIN + int'($urandom_range(1000));
      step = $urandom_range(1000, 1);
      for (int i = 0; i < MAX_ELEMS + 2; i++) begin
         add_item(v, i == MAX_ELEMS + 1, i == 0);
         v = v + step;
      end

      while (pending_items.size() < TARGET_ITEMS) begin
         if (pending_items.size() < TARGET_ITEMS - 400 && $urandom_range(29) == 0) begin
            seq_len = $urandom_range(MAX_ELEMS + 40, MAX_ELEMS - 4);
         end else begin
            seq_len = $urandom_range(24, 1);
         end
         hold = ($urandom_range(14) == 0);
         v    = int'($urandom_range(64)) - 32;
         for (int i = 0; i < seq_len; i++) begin
            v = pick_value(v);
            add_item(v, i == seq_len - 1, hold && i == 0);
         end
      end
   endtask

   always @(posedge clock) begin : drive_requests
      stim_item_type nxt;
      bit            idle_now;
      bit            next_valid;
      req_type       next_data;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_data  = req_data;
         if (req_valid && req_ready) begin
            expected_results.push_back(score_element(req_data));
            sent_count++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_items.size() != 0) begin
            idle_now = (sent_count < QUIET_FIRST || sent_count >= QUIET_LAST)
                       && $urandom_range(99) < IDLE_PCT;
            if (pending_items[0].hold && expected_results.size() != 0) begin
               idle_now = 1'b1;
            end
            if (!idle_now) begin
               nxt        = pending_items.pop_front();
               next_valid = 1'b1;
               next_data  = nxt.data;
            end
         end
         req_valid <= next_valid;
         req_data  <= next_data;
      end
   end

   always @(posedge clock) begin : check_responses
      rsp_type want;
      bit      stall;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               $error("response with no transaction outstanding: %p", rsp_data);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.end_length !== want.end_length) begin
                  $error("end_length: expected %0d, got %0d", want.end_length,
                         rsp_data.end_length);
                  error_count++;
               end
               if (rsp_data.best_length !== want.best_length) begin
                  $error("best_length: expected %0d, got %0d", want.best_length,
                         rsp_data.best_length);
                  error_count++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
                  error_count++;
               end
               if (rsp_data.is_last !== want.is_last) begin
                  $error("is_last: expected %0b, got %0b", want.is_last, rsp_data.is_last);
                  error_count++;
               end
            end
            recv_count++;
         end
         stall = (recv_count < QUIET_FIRST || recv_count >= QUIET_LAST)
                 && $urandom_range(99) < IDLE_PCT;
         rsp_ready <= !stall;
      end
   end

   initial begin
      build_stimulus();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      do begin
         @(negedge clock);
      end while (pending_items.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/lis_pkg.sv
hw/rtl/lis_cell.sv
hw/rtl/longest_increasing_subsequence.sv
hw/rtl/lis_checker.sv
test/longest_increasing_subsequence_tb.sv
